// ===== hw/rtl/token_run_coalescer_defines.svh =====
// Assertion macros for the token run coalescer.
// Used by the top level; the macros expand to nothing in synthesis.
`ifndef TOKEN_RUN_COALESCER_DEFINES_SVH
`define TOKEN_RUN_COALESCER_DEFINES_SVH
`ifndef SYNTHESIS
`define TRC_ASSERT_CLK(lbl, prop, msg) lbl: assert property (@(posedge aclk) \
    disable iff (!aresetn) (prop)) else $error(msg);
`define TRC_ASSERT_RST(lbl, prop, msg) lbl: assert property (@(posedge aclk) \
    (prop)) else $error(msg);
`else
`define TRC_ASSERT_CLK(lbl, prop, msg)
`define TRC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/trc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the token run coalescer.
// Has no dependencies; used by trc_cell and token_run_coalescer.
package trc_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int TOKEN_W     = 32;
    localparam int COUNT_W     = 16;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRIES_W   = 5;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUN_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = CFG_IDX_W'(1);

    localparam logic [COUNT_W-1:0]   RESET_MAX_RUN = COUNT_W'(1280);
    localparam logic [ENTRIES_W-1:0] RESET_ENTRIES = ENTRIES_W'(16);
    localparam logic [COUNT_W-1:0]   COUNT_SAT     = '1;

    localparam logic CAUSE_LIMIT = 1'b0;
    localparam logic CAUSE_FULL  = 1'b1;

    typedef struct packed {
        logic step;
        logic shift;
        logic active;
    } cell_ctrl_t;

    typedef struct packed {
        logic [TOKEN_W-1:0] start;
        logic [COUNT_W-1:0] count;
    } run_t;

endpackage

// ===== hw/rtl/token_run_coalescer.sv =====
`timescale 1ns / 1ps
// Top level of the token run coalescer: a row of run cells, flush control and output register.
// Depends on trc_pkg, trc_cell and token_run_coalescer_defines.svh.

// Each accepted token is compared against every active cell of the row, and the first
// cell that is empty or whose run the token extends takes it; such a token yields no
// result. A flush (a run reaching max_run_length or the saturation count, or no cell
// able to take the token) shifts the row toward cell 0 one cell per cycle, holding while
// m_ready holds back a result, and releases each occupied run as one transfer; s_ready
// stays low until the flush is done. When the table was full, the token that caused the
// flush then starts a new run in cell 0.
`include "token_run_coalescer_defines.svh"

module token_run_coalescer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [trc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [trc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [trc_pkg::TOKEN_W-1:0]    s_frag_token_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [trc_pkg::TOKEN_W-1:0]    m_run_first,
    output logic [trc_pkg::COUNT_W-1:0]    m_run_length,
    output logic                           m_flush_cause,
    output logic                           m_last_of_flush
);

    localparam int DEPTH = trc_pkg::TABLE_DEPTH;

    typedef enum logic [0:0] {ST_IDLE, ST_FLUSH} state_t;

    state_t                          state_reg, state_next;
    logic                            cause_reg, cause_next;
    logic                            install_reg, install_next;
    logic [trc_pkg::TOKEN_W-1:0]     tok_reg, tok_next;
    logic [trc_pkg::COUNT_W-1:0]     max_run_reg, max_run_next;
    logic [trc_pkg::ENTRIES_W-1:0]   entries_reg, entries_next;
    logic                            m_valid_reg, m_valid_next;
    logic [trc_pkg::TOKEN_W-1:0]     m_run_first_reg;
    logic [trc_pkg::COUNT_W-1:0]     m_run_length_reg;
    logic                            m_flush_cause_reg;
    logic                            m_last_of_flush_reg;

    logic [trc_pkg::CNT_W-1:0]       n_eff;
    logic [DEPTH-1:0]                active;
    logic [DEPTH-1:0]                occ;
    logic [DEPTH-1:0]                pend;
    logic [DEPTH-1:0]                flush_vec;
    logic [DEPTH:0]                  taken;
    trc_pkg::run_t                   runs [DEPTH];
    trc_pkg::run_t                   nb   [DEPTH];
    trc_pkg::cell_ctrl_t             ctrl [DEPTH];
    logic [trc_pkg::TOKEN_W-1:0]     cell_token;

    logic step;
    logic shift;
    logic load_out;
    logic out_free;
    logic full;
    logic grow_flush;
    logic last;

    always_comb begin
        if (entries_reg == '0) begin
            n_eff = trc_pkg::CNT_W'(1);
        end else if (32'(entries_reg) > DEPTH) begin
            n_eff = trc_pkg::CNT_W'(DEPTH);
        end else begin
            n_eff = trc_pkg::CNT_W'(entries_reg);
        end
    end

    assign taken[0]   = 1'b0;
    assign cell_token = (state_reg == ST_IDLE) ? s_frag_token_value : tok_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign active[i] = 32'(i) < 32'(n_eff);
        assign occ[i]    = runs[i].count != '0;
        assign ctrl[i]   = '{step: step, shift: shift, active: active[i]};
        if (i < DEPTH - 1) begin : g_nb
            assign nb[i] = active[i+1] ? runs[i+1] : '0;
        end else begin : g_nb_end
            assign nb[i] = '0;
        end
        trc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl[i]),
            .token     (cell_token),
            .max_run   (max_run_reg),
            .taken_in  (taken[i]),
            .nb_run    (nb[i]),
            .taken_out (taken[i+1]),
            .flush_req (flush_vec[i]),
            .run       (runs[i])
        );
    end

    assign pend       = occ & active;
    assign full       = !taken[DEPTH];
    assign grow_flush = |flush_vec;
    assign last       = (pend >> 1) == '0;
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cause_next   = cause_reg;
        install_next = install_reg;
        tok_next     = tok_reg;
        max_run_next = max_run_reg;
        entries_next = entries_reg;
        step         = 1'b0;
        shift        = 1'b0;
        load_out     = 1'b0;

        if (cfg_wr_en) begin
            case (cfg_index)
                trc_pkg::CFG_MAX_RUN_LENGTH: max_run_next = cfg_wdata;
                trc_pkg::CFG_ENTRIES_IN_USE: entries_next = cfg_wdata[trc_pkg::ENTRIES_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    step = 1'b1;
                    if (full) begin
                        state_next   = ST_FLUSH;
                        cause_next   = trc_pkg::CAUSE_FULL;
                        install_next = 1'b1;
                        tok_next     = s_frag_token_value;
                    end else if (grow_flush) begin
                        state_next   = ST_FLUSH;
                        cause_next   = trc_pkg::CAUSE_LIMIT;
                        install_next = 1'b0;
                    end
                end
            end
            ST_FLUSH: begin
                if (pend == '0) begin
                    state_next   = ST_IDLE;
                    step         = install_reg;
                    install_next = 1'b0;
                end else if (pend[0]) begin
                    if (out_free) begin
                        load_out = 1'b1;
                        shift    = 1'b1;
                    end
                end else begin
                    shift = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cause_reg   <= trc_pkg::CAUSE_LIMIT;
            install_reg <= 1'b0;
            max_run_reg <= trc_pkg::RESET_MAX_RUN;
            entries_reg <= trc_pkg::RESET_ENTRIES;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cause_reg   <= cause_next;
            install_reg <= install_next;
            max_run_reg <= max_run_next;
            entries_reg <= entries_next;
            m_valid_reg <= m_valid_next;
        end
        tok_reg <= tok_next;
        if (load_out) begin
            m_run_first_reg     <= runs[0].start;
            m_run_length_reg    <= runs[0].count;
            m_flush_cause_reg   <= cause_reg;
            m_last_of_flush_reg <= last;
        end
    end

    assign s_ready         = state_reg == ST_IDLE;
    assign m_valid         = m_valid_reg;
    assign m_run_first     = m_run_first_reg;
    assign m_run_length    = m_run_length_reg;
    assign m_flush_cause   = m_flush_cause_reg;
    assign m_last_of_flush = m_last_of_flush_reg;

    // A flush only ever drains the row; no occupied cell appears while it runs.
    `TRC_ASSERT_CLK(a_flush_drains, (state_reg == ST_FLUSH && $past(state_reg == ST_FLUSH)) |-> ($countones(pend) <= $past($countones(pend))), "occupied cells grew during a flush")
    // A token that finds no cell must start a table-full flush that reinstalls it.
    `TRC_ASSERT_CLK(a_full_flush, (s_valid && s_ready && full) |=> (state_reg == ST_FLUSH && cause_reg == trc_pkg::CAUSE_FULL && install_reg), "table-full token did not start a flush")
    // Reset leaves every cell empty and no transfer pending.
    `TRC_ASSERT_RST(a_reset_empty, !aresetn |=> (occ == '0 && !m_valid), "table not empty after reset")

endmodule

// ===== hw/rtl/trc_cell.sv =====
`timescale 1ns / 1ps
// One table entry of the coalescer: holds a run, matches a token, shifts toward entry 0.
// Depends on trc_pkg.
module trc_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  trc_pkg::cell_ctrl_t         ctrl,
    input  logic [trc_pkg::TOKEN_W-1:0] token,
    input  logic [trc_pkg::COUNT_W-1:0] max_run,
    input  logic                        taken_in,
    input  trc_pkg::run_t               nb_run,
    output logic                        taken_out,
    output logic                        flush_req,
    output trc_pkg::run_t               run
);

    trc_pkg::run_t run_reg;
    trc_pkg::run_t run_next;

    logic                        occupied;
    logic                        hit_empty;
    logic                        hit_match;
    logic                        sel;
    logic                        at_limit;
    logic [trc_pkg::TOKEN_W-1:0] end_tok;
    logic [trc_pkg::COUNT_W:0]   grown;

    always_comb begin
        occupied  = run_reg.count != '0;
        end_tok   = run_reg.start + trc_pkg::TOKEN_W'(run_reg.count);
        hit_empty = ctrl.active && !occupied;
        hit_match = ctrl.active && occupied && (end_tok == token);
        sel       = !taken_in && (hit_empty || hit_match);
        taken_out = taken_in || hit_empty || hit_match;
        grown     = {1'b0, run_reg.count} + (trc_pkg::COUNT_W + 1)'(1);
        at_limit  = (grown >= {1'b0, max_run}) || (grown >= {1'b0, trc_pkg::COUNT_SAT});
        flush_req = sel && hit_match && at_limit;

        run_next = run_reg;
        if (ctrl.step && sel) begin
            if (hit_empty) begin
                run_next.start = token;
                run_next.count = trc_pkg::COUNT_W'(1);
            end else begin
                run_next.count = grown[trc_pkg::COUNT_W-1:0];
            end
        end else if (ctrl.shift && ctrl.active) begin
            run_next = nb_run;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= '0;
        end else begin
            run_reg <= run_next;
        end
    end

    assign run = run_reg;

endmodule
